### src/float_angle_quadrant_reducer_unit_macros.svh
// ----------------------------------------------------------------------------
// float angle quadrant reducer assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef FLOAT_ANGLE_QUADRANT_REDUCER_UNIT_MACROS_SVH
`define FLOAT_ANGLE_QUADRANT_REDUCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define FAQR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FAQR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FAQR_ASSERT_IMPL(lbl, ante, cons, msg)
`define FAQR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/faqr_pkg.sv
// ----------------------------------------------------------------------------
// faqr_pkg
// constants and types of the float angle quadrant reducer
// ----------------------------------------------------------------------------
`default_nettype none

package faqr_pkg;

	// float decode
	localparam int MantW = 24;
	localparam logic [7:0] ExpAllOnes = 8'd255;
	localparam logic [7:0] ExpShiftZero = 8'd118;  // biased exponent with no mantissa shift
	localparam logic [7:0] ExpTooLarge = 8'd158;   // |angle| >= 2^31 from here up

	// floor(2^40 / 360), quotient estimate low by at most one
	localparam logic [31:0] RecipTurn = 32'd3054198966;
	// floor(2^32 / 180)
	localparam logic [24:0] ScaleK = 25'd23860929;

	localparam logic [9:0] TurnDeg10 = 10'd360;
	localparam logic [8:0] TurnDeg = 9'd360;
	localparam logic [8:0] HalfDeg = 9'd180;
	localparam logic [7:0] HalfDeg8 = 8'd180;
	localparam logic [7:0] QuadDeg = 8'd90;
	localparam logic [7:0] OctDeg = 8'd45;
	localparam logic [7:0] Oct3Deg = 8'd135;

	// output transaction layout
	localparam int AngleW = 32;
	localparam int FlipsW = 3;
	localparam int MDataW = 40;

	typedef logic signed [FlipsW-1:0] flips_t;

	localparam flips_t FlipsPos1 = 3'sd1;
	localparam flips_t FlipsPos2 = 3'sd2;
	localparam flips_t FlipsNeg1 = -3'sd1;
	localparam flips_t FlipsNeg2 = -3'sd2;
	localparam flips_t FlipsZero = 3'sd0;

endpackage

`default_nettype wire

### src/float_angle_quadrant_reducer_unit.sv
// ----------------------------------------------------------------------------
// float_angle_quadrant_reducer_unit
// an input transaction passes through stage registers s1 to s8, and vld_s8 drives m_tvalid
// throughput: one transaction per cycle while m_tready is high, set by the 8-stage register pipeline
// a stalled output stage holds; upstream stages with bubbles keep accepting
// reset: arst_n clears all stage valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none
`include "float_angle_quadrant_reducer_unit_macros.svh"

module float_angle_quadrant_reducer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input stream
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [31:0]                 s_tdata,   // [31:0] angle_bits
	// result stream
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [faqr_pkg::MDataW-1:0]      m_tdata    // [31:0] reduced_angle,
	                                                    // [34:32] quadrant_flips,
	                                                    // [35] out_of_range, [39:36] zero
);
	import faqr_pkg::*;

	// stage valid bits and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	// a stage loads when it is empty or the stage after it loads too,
	// so bubbles collapse while the output waits
	assign en_s8 = !vld_s8 || m_tready;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: float decode into Q32.32 magnitude
	// ------------------------------------------------------------------
	logic [7:0]       exp_in;
	logic [MantW-1:0] mant;
	logic             is_special;
	logic             is_oor;
	logic [5:0]       lsh;
	logic [7:0]       rsh;
	logic [63:0]      mag;

	always_comb begin
		exp_in     = s_tdata[30:23];
		mant       = {1'b1, s_tdata[22:0]};
		// zero, denormal, infinity and nan all come out as zero
		is_special = (exp_in == 8'd0) || (exp_in == ExpAllOnes);
		is_oor     = !is_special && (exp_in >= ExpTooLarge);
		lsh        = 6'(exp_in - ExpShiftZero);
		rsh        = ExpShiftZero - exp_in;
		if (exp_in >= ExpShiftZero) begin
			mag = {40'd0, mant} << lsh;
		end else if (rsh < 8'(MantW)) begin
			mag = {40'd0, mant} >> rsh[4:0];
		end else begin
			mag = '0;
		end
		// resolution stops at 2^-31
		mag[0] = 1'b0;
		if (is_special || is_oor) begin
			mag = '0;
		end
	end

	logic [30:0] int_s1;
	logic [31:0] frac_s1;
	logic        neg_s1;
	logic        oor_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			int_s1  <= mag[62:32];
			frac_s1 <= mag[31:0];
			neg_s1  <= s_tdata[31] && !is_special && !is_oor;
			oor_s1  <= is_oor;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: quotient estimate of int / 360 by reciprocal multiply
	// ------------------------------------------------------------------
	logic [62:0] prod_s2;
	logic [9:0]  int_lo_s2;
	logic [31:0] frac_s2;
	logic        neg_s2;
	logic        oor_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			prod_s2   <= 63'(int_s1) * 63'(RecipTurn);
			int_lo_s2 <= int_s1[9:0];
			frac_s2   <= frac_s1;
			neg_s2    <= neg_s1;
			oor_s2    <= oor_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: raw remainder, in [0,720) since the estimate is low by <= 1
	// only the low ten bits of int - q*360 are needed
	// ------------------------------------------------------------------
	logic [9:0]  q_lo;
	logic [9:0]  rem_raw_s3;
	logic [31:0] frac_s3;
	logic        neg_s3;
	logic        oor_s3;

	assign q_lo = prod_s2[49:40];

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rem_raw_s3 <= int_lo_s2 - 10'(q_lo * TurnDeg10);
			frac_s3    <= frac_s2;
			neg_s3     <= neg_s2;
			oor_s3     <= oor_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: remainder correction, whole turns removed
	// ------------------------------------------------------------------
	logic [8:0]  rint_s4;
	logic [31:0] frac_s4;
	logic        neg_s4;
	logic        oor_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rint_s4 <= (rem_raw_s3 >= TurnDeg10) ? 9'(rem_raw_s3 - TurnDeg10)
			                                     : rem_raw_s3[8:0];
			frac_s4 <= frac_s3;
			neg_s4  <= neg_s3;
			oor_s4  <= oor_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: fold (180,360) onto the negative half as a magnitude
	// ------------------------------------------------------------------
	logic        above_half;
	logic [40:0] fold_mag;

	always_comb begin
		above_half = (rint_s4 > HalfDeg) || ((rint_s4 == HalfDeg) && (frac_s4 != 32'd0));
		if (above_half) begin
			fold_mag = {TurnDeg, 32'd0} - {rint_s4, frac_s4};
		end else begin
			fold_mag = {rint_s4, frac_s4};
		end
	end

	logic [39:0] amag_s5;   // Q8.32, at most 180
	logic        sgn_s5;
	logic        oor_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			amag_s5 <= fold_mag[39:0];
			sgn_s5  <= neg_s4 ^ above_half;
			oor_s5  <= oor_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 6: quarter turns, magnitude into [-45,45], then apply sign
	// ------------------------------------------------------------------
	logic [7:0]         a_int;
	logic [31:0]        a_frac;
	logic               gt_oct;
	logic               gt_oct3;
	logic [7:0]         ar_int;
	logic signed [39:0] ar;
	logic signed [39:0] vsig;
	flips_t             flips_mag;

	always_comb begin
		a_int   = amag_s5[39:32];
		a_frac  = amag_s5[31:0];
		gt_oct  = (a_int > OctDeg) || ((a_int == OctDeg) && (a_frac != 32'd0));
		gt_oct3 = (a_int > Oct3Deg) || ((a_int == Oct3Deg) && (a_frac != 32'd0));
		priority if (gt_oct3) begin
			ar_int    = a_int - HalfDeg8;
			flips_mag = FlipsNeg2;
		end else if (gt_oct) begin
			ar_int    = a_int - QuadDeg;
			flips_mag = FlipsNeg1;
		end else begin
			ar_int    = a_int;
			flips_mag = FlipsZero;
		end
		// signed integer part over unsigned fraction is plain two's complement
		ar   = $signed({ar_int, a_frac});
		vsig = sgn_s5 ? -ar : ar;
	end

	logic signed [38:0] v_s6;
	flips_t             flips_s6;
	logic               oor_s6;

	always_ff @(posedge clk) begin
		if (en_s6) begin
			v_s6     <= vsig[38:0];
			flips_s6 <= sgn_s5 ? -flips_mag : flips_mag;
			oor_s6   <= oor_s5;
		end
	end

	// ------------------------------------------------------------------
	// stage 7: scale by floor(2^32/180) as two partial products
	// ------------------------------------------------------------------
	logic signed [18:0] v_hi;
	logic [19:0]        v_lo;

	assign v_hi = v_s6[38:20];
	assign v_lo = v_s6[19:0];

	logic signed [44:0] ph_s7;
	logic [44:0]        pl_s7;
	flips_t             flips_s7;
	logic               oor_s7;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			ph_s7    <= 45'(v_hi * $signed({1'b0, ScaleK}));
			pl_s7    <= 45'(v_lo) * 45'(ScaleK);
			flips_s7 <= flips_s6;
			oor_s7   <= oor_s6;
		end
	end

	// ------------------------------------------------------------------
	// stage 8: partial product sum, floor shift by 32, output register
	// ------------------------------------------------------------------
	logic [63:0] prod_sum;

	assign prod_sum = ({{19{ph_s7[44]}}, ph_s7} << 20) + {19'd0, pl_s7};

	logic signed [AngleW-1:0] angle_s8;
	flips_t                   flips_s8;
	logic                     oor_s8;

	always_ff @(posedge clk) begin
		if (en_s8) begin
			angle_s8 <= $signed(prod_sum[63:32]);
			flips_s8 <= flips_s7;
			oor_s8   <= oor_s7;
		end
	end

	assign m_tvalid = vld_s8;
	assign m_tdata  = {4'd0, oor_s8, flips_s8, angle_s8};

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`FAQR_ASSERT_IMPL(a_rem_range, vld_s3, rem_raw_s3 < 10'd720, "remainder estimate off by more than one turn")
	`FAQR_ASSERT_IMPL(a_oor_zero, vld_s8 && oor_s8, (angle_s8 == '0) && (flips_s8 == FlipsZero), "out of range result not zero")
	`FAQR_ASSERT_IMPL(a_flips_range, vld_s8, (flips_s8 != 3'b011) && (flips_s8 != 3'b100), "quadrant flips outside -2..2")
	`FAQR_ASSERT_IMPL(a_angle_range, vld_s8, (angle_s8 >= -32'sd1073741824) && (angle_s8 <= 32'sd1073741824), "reduced angle outside +-45 degrees")
	`FAQR_ASSERT_NEXT(a_accept_fill, s_tvalid && s_tready, vld_s1, "accepted transaction not in stage 1")

endmodule

`default_nettype wire
